@@ src/piecewise_linear_table_interp_top_defines.svh @@
// Assertion macros used by the port-level checker
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_TOP_DEFINES_SVH

// same-cycle implication
`define PLTI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plti assertion failed");

// next-cycle implication
`define PLTI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plti assertion failed");

`endif

@@ src/plti_pkg.sv @@
// Package: types and constants of the table interpolator
`default_nettype none
package plti_pkg;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = 6;
   localparam int LEN_W     = 7;
   localparam int RULE_W    = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_RULE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_FILL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_FILL   = 2'd3;

   localparam logic [RULE_W-1:0] RULE_UPPER       = 2'd0;
   localparam logic [RULE_W-1:0] RULE_UPPER_LOWER = 2'd1;
   localparam logic [RULE_W-1:0] RULE_CLAMP       = 2'd2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   localparam logic signed [DATA_W-1:0] FILL_RESET = 32'sd65536;  // 1.0

   typedef struct packed {
      logic signed [DATA_W-1:0] bp;
      logic signed [DATA_W-1:0] val;
   } plti_entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } plti_div_stat_type;
endpackage
`default_nettype wire

@@ src/plti_req_if.sv @@
// Request and response channel interfaces
`default_nettype none
interface plti_req_if;
   import plti_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [IDX_W-1:0]         entry_index;
   logic signed [DATA_W-1:0] entry_breakpoint;
   logic signed [DATA_W-1:0] entry_value;
   logic signed [DATA_W-1:0] query;
   modport source (output valid, op, entry_index, entry_breakpoint, entry_value, query,
                   input ready);
   modport sink (input valid, op, entry_index, entry_breakpoint, entry_value, query,
                 output ready);
endinterface

interface plti_rsp_if;
   import plti_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [LEN_W-1:0]         segment;
   logic                     fill_used;
   modport source (output valid, result_value, segment, fill_used, input ready);
   modport sink (input valid, result_value, segment, fill_used, output ready);
endinterface
`default_nettype wire

@@ src/piecewise_linear_table_interp_top.sv @@
// Piecewise-linear table interpolator, Q16.16. A write item (op 0) stores one
// breakpoint/value pair in the table memory. An evaluate item (op 1) scans
// the table from entry 0, one memory read per cycle, until the first
// breakpoint not below the query or the end of the configured table, then
// returns an edge value, the lower value of a flat or falling segment, or
// interpolates with one 32x32 multiply and a bit-serial divide. An evaluate
// goes through the scan, a decide state, for an interpolation a multiply
// state and the divider, and then into the output register, which may wait
// for the receiver. The scan over the single memory read port and the serial
// divider take most of its time; one item is worked on at a time. Table
// contents are undefined after reset until written.
`default_nettype none
module piecewise_linear_table_interp_top
   import plti_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   plti_req_if.sink                  req_ch,
   plti_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_wdata
);
   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW0 = $clog2(TABLE_DEPTH + 1);
   localparam int NW  = (CW0 > LEN_W) ? CW0 : LEN_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_DIVGO  = 3'd4;
   localparam logic [2:0] ST_DIVW   = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   // configuration registers
   logic [LEN_W-1:0]         len_ff;
   logic [RULE_W-1:0]        rule_ff;
   logic signed [DATA_W-1:0] upper_ff;
   logic signed [DATA_W-1:0] lower_ff;

   logic [2:0]               state_ff, state_in;
   logic signed [DATA_W-1:0] q_ff, q_in;
   logic [AW-1:0]            cnt_ff, cnt_in;
   logic [NW-1:0]            j_ff, j_in;
   plti_entry_type           prev_ff, prev_in;
   plti_entry_type           cur_ff, cur_in;
   logic signed [DATA_W-1:0] v0_ff, v0_in;
   logic                     neg_ff, neg_in;
   logic [DATA_W-1:0]        mag_ff, mag_in;
   logic [DATA_W-1:0]        dq_ff, dq_in;
   logic [DATA_W-1:0]        dx_ff, dx_in;
   logic [2*DATA_W-1:0]      prod_ff, prod_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     fill_ff, fill_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_res_ff, rsp_res_in;
   logic [LEN_W-1:0]         rsp_seg_ff, rsp_seg_in;
   logic                     rsp_fill_ff, rsp_fill_in;

   logic                     req_xfer;
   logic [NW-1:0]            n_eff;
   logic [RULE_W-1:0]        rule_eff;
   plti_entry_type           wr_data;
   plti_entry_type           rd_data;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic                     div_start;
   plti_div_stat_type        div_stat;
   logic [DATA_W-1:0]        quot;
   logic signed [DATA_W:0]   dx_s, dq_s, dv_s;
   logic signed [DATA_W+1:0] sum;

   assign req_xfer = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      if (len_ff < LEN_W'(2)) begin
         n_eff = NW'(2);
      end else if (NW'(len_ff) > NW'(TABLE_DEPTH)) begin
         n_eff = NW'(TABLE_DEPTH);
      end else begin
         n_eff = NW'(len_ff);
      end
      rule_eff = (rule_ff == RULE_CLAMP) ? RULE_CLAMP : rule_ff;
      if (rule_ff != RULE_UPPER_LOWER && rule_ff != RULE_CLAMP) begin
         rule_eff = RULE_UPPER;
      end
   end

   assign wr_en       = req_xfer && (req_ch.op == OP_WRITE) &&
                        ({{(32-IDX_W){1'b0}}, req_ch.entry_index} < 32'(TABLE_DEPTH));
   assign wr_data.bp  = req_ch.entry_breakpoint;
   assign wr_data.val = req_ch.entry_value;
   assign rd_addr     = (state_ff == ST_SCAN) ? cnt_ff + 1'b1 : '0;
   assign div_start   = (state_ff == ST_DIVGO);

   plti_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_ch.entry_index)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .stat     (div_stat),
      .quot     (quot)
   );

   always_comb begin
      state_in     = state_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      j_in         = j_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      v0_in        = v0_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      dq_in        = dq_ff;
      dx_in        = dx_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_fill_in  = rsp_fill_ff;

      dx_s = {cur_ff.bp[DATA_W-1], cur_ff.bp} - {prev_ff.bp[DATA_W-1], prev_ff.bp};
      dq_s = {q_ff[DATA_W-1], q_ff} - {prev_ff.bp[DATA_W-1], prev_ff.bp};
      dv_s = {cur_ff.val[DATA_W-1], cur_ff.val} - {prev_ff.val[DATA_W-1], prev_ff.val};
      sum  = neg_ff ? {{2{v0_ff[DATA_W-1]}}, v0_ff} - {2'b00, quot}
                    : {{2{v0_ff[DATA_W-1]}}, v0_ff} + {2'b00, quot};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_ch.op == OP_EVAL) begin
               q_in     = req_ch.query;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rd_data holds entry cnt_ff
            if (q_ff > rd_data.bp) begin
               prev_in = rd_data;
               if (NW'(cnt_ff) + 1'b1 == n_eff) begin
                  j_in     = n_eff;
                  state_in = ST_DECIDE;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               cur_in   = rd_data;
               j_in     = NW'(cnt_ff);
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            fill_in  = 1'b1;
            state_in = ST_OUT;
            if (rule_eff == RULE_CLAMP && j_ff == n_eff) begin
               res_in = prev_ff.val;
            end else if (rule_eff != RULE_CLAMP && j_ff >= n_eff - 1'b1) begin
               res_in = upper_ff;
            end else if (j_ff == '0) begin
               res_in = (rule_eff == RULE_UPPER_LOWER) ? lower_ff : cur_ff.val;
            end else begin
               fill_in = 1'b0;
               if (dx_s <= 0) begin
                  // flat or falling segment gives the lower value
                  res_in = prev_ff.val;
               end else begin
                  v0_in  = prev_ff.val;
                  neg_in = dv_s[DATA_W];
                  mag_in = dv_s[DATA_W] ? DATA_W'(-dv_s) : dv_s[DATA_W-1:0];
                  dx_in  = dx_s[DATA_W-1:0];
                  if (dq_s < 0) begin
                     dq_in = '0;
                  end else if (dq_s > dx_s) begin
                     dq_in = dx_s[DATA_W-1:0];
                  end else begin
                     dq_in = dq_s[DATA_W-1:0];
                  end
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = mag_ff * dq_ff;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_stat.done) begin
               if (sum > 34'sh0_7FFF_FFFF) begin
                  res_in = 32'sh7FFF_FFFF;
               end else if (sum < -34'sh0_8000_0000) begin
                  res_in = 32'sh8000_0000;
               end else begin
                  res_in = sum[DATA_W-1:0];
               end
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_seg_in   = j_ff[LEN_W-1:0];
               rsp_fill_in  = fill_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= LEN_W'(64);
         rule_ff      <= RULE_UPPER;
         upper_ff     <= FILL_RESET;
         lower_ff     <= FILL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TABLE_LENGTH: len_ff   <= csr_wdata[LEN_W-1:0];
               CSR_END_RULE:     rule_ff  <= csr_wdata[RULE_W-1:0];
               CSR_UPPER_FILL:   upper_ff <= csr_wdata;
               CSR_LOWER_FILL:   lower_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      j_ff        <= j_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      v0_ff       <= v0_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      dq_ff       <= dq_in;
      dx_ff       <= dx_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      fill_ff     <= fill_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_fill_ff <= rsp_fill_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_res_ff;
   assign rsp_ch.segment      = rsp_seg_ff;
   assign rsp_ch.fill_used    = rsp_fill_ff;
endmodule
`default_nettype wire

@@ src/plti_table.sv @@
// Breakpoint/value table memory, one write and one registered read port
`default_nettype none
module plti_table
   import plti_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic           clock,
   input  wire logic           wr_en,
   input  wire logic [AW-1:0]  wr_addr,
   input  wire plti_entry_type wr_data,
   input  wire logic [AW-1:0]  rd_addr,
   output plti_entry_type      rd_data
);
   plti_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/plti_div.sv @@
// Restoring divider, one quotient bit per cycle, 32-bit quotient
`default_nettype none
module plti_div
   import plti_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [2*DATA_W-1:0]  dividend,
   input  wire logic [DATA_W-1:0]    divisor,
   output plti_div_stat_type         stat,
   output logic [DATA_W-1:0]         quot
);
   localparam int SW = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [SW-1:0]     step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, lo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper half is below the divisor, so the quotient fits 32 bits
         rem_in  = dividend[2*DATA_W-1:DATA_W];
         lo_in   = dividend[DATA_W-1:0];
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
         lo_in   = {lo_ff[DATA_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == SW'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      step_ff <= step_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = lo_ff;
endmodule
`default_nettype wire

@@ src/plti_checker.sv @@
// Port-level checker for the table interpolator, bound to the top level
`default_nettype none
`include "piecewise_linear_table_interp_top_defines.svh"
module plti_checker
   import plti_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_op,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_result_value,
   input wire logic [LEN_W-1:0]         rsp_segment,
   input wire logic                     rsp_fill_used
);
   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   `PLTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_value))
   `PLTI_ASSERT_NEXT(a_write_silent, clock, reset, req_xfer && req_op == OP_WRITE && !rsp_valid, !rsp_valid)
   `PLTI_ASSERT_NEXT(a_eval_busy, clock, reset, req_xfer && req_op == OP_EVAL, !req_ready)
   `PLTI_ASSERT_SAME(a_interp_segment, clock, reset, rsp_valid && !rsp_fill_used, rsp_segment != '0)
endmodule

bind piecewise_linear_table_interp_top plti_checker u_plti_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_op           (req_ch.op),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_segment      (rsp_ch.segment),
   .rsp_fill_used    (rsp_ch.fill_used)
);
`default_nettype wire
